@@ rtl/bcd_pkg.sv @@
// Shared types, format codes and divide-by-constant helpers for the block decoder.
`timescale 1ns / 1ps
`default_nettype none
package bcd_pkg;

   localparam int unsigned PIXELS      = 16;
   localparam int unsigned ALPHA_LANES = 6;
   localparam int unsigned BC3_IDX_LSB = 16;

   localparam logic [1:0] FMT_BC1 = 2'd0;
   localparam logic [1:0] FMT_BC2 = 2'd1;
   localparam logic [1:0] FMT_BC3 = 2'd2;

   localparam logic [3:0]  LAST_PIXEL  = 4'(PIXELS - 1);
   localparam logic [7:0]  DIV3_RECIP  = 8'd171;
   localparam logic [11:0] DIV5_RECIP  = 12'd3277;
   localparam logic [12:0] DIV7_RECIP  = 13'd4682;
   localparam logic [7:0]  ALPHA_OPAQUE = 8'hFF;

   typedef struct packed {
      logic [63:0] alpha_word;
      logic [15:0] color_end_a;
      logic [15:0] color_end_b;
      logic [31:0] color_index_word;
   } bcd_req_type;

   typedef struct packed {
      logic [15:0] pixel_color;
      logic [7:0]  pixel_alpha;
      logic [3:0]  pixel_position;
      logic        block_last;
   } bcd_rsp_type;

   typedef struct packed {
      logic [1:0]       fmt;
      logic [63:0]      alpha_word;
      logic [31:0]      color_index_word;
      logic [3:0][15:0] palette;
   } bcd_block_type;

   // floor(x / 3), exact for every 8-bit x
   function automatic logic [6:0] div3(input logic [7:0] x);
      logic [15:0] prod;
      prod = {8'd0, x} * {8'd0, DIV3_RECIP};
      return prod[15:9];
   endfunction

   // floor(x / 5), exact for x <= 1275
   function automatic logic [7:0] div5(input logic [10:0] x);
      logic [22:0] prod;
      prod = {12'd0, x} * {11'd0, DIV5_RECIP};
      return prod[21:14];
   endfunction

   // floor(x / 7), exact for x <= 1785
   function automatic logic [7:0] div7(input logic [10:0] x);
      logic [23:0] prod;
      prod = {13'd0, x} * {11'd0, DIV7_RECIP};
      return prod[22:15];
   endfunction

endpackage
`default_nettype wire

@@ rtl/bc1_bc2_bc3_block_decoder.sv @@
// Top level of the BC1/BC2/BC3 block decoder: block register, palette lanes, pixel merge.
//
//   channel  ports                              direction  handshake
//   request  start, busy, req_data              in         start & !busy
//   result   rsp_strobe, rsp_data               out        strobe, one cycle, no stall
//   config   csr_valid, csr_ready, csr_data     in         valid & ready
//
// A block yields 16 pixels on consecutive cycles, one per cycle, set by the merge stage.
// A new block is taken while the previous one is emitted.
// A taken request passes through the block register, then the merge stage registers, to its first pixel.
// Synchronous reset clears control state and selects BC1.
// busy is high only while a block waits in the block register for the merge stage.
`timescale 1ns / 1ps
`default_nettype none
module bc1_bc2_bc3_block_decoder (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  start,
   output logic                       busy,
   input  wire bcd_pkg::bcd_req_type  req_data,
   output logic                       rsp_strobe,
   output bcd_pkg::bcd_rsp_type       rsp_data,
   input  wire logic                  csr_valid,
   output logic                       csr_ready,
   input  wire logic [1:0]            csr_data
);

   logic                   accept;
   logic                   load;
   logic                   merge_free;
   logic                   blk_valid_ff;
   logic                   blk_valid_in;
   logic [1:0]             block_format_ff;
   logic [1:0]             block_format_in;
   bcd_pkg::bcd_block_type blk_ff;
   bcd_pkg::bcd_block_type blk_in;
   logic [15:0]            mix_near;
   logic [15:0]            mix_far;
   logic [5:0][7:0]        lane_seven;
   logic [5:0][7:0]        lane_five;

   assign csr_ready = 1'b1;
   assign load      = blk_valid_ff && merge_free;
   assign busy      = blk_valid_ff && !merge_free;
   assign accept    = start && !busy;

   bcd_color_lane u_color_near (
      .color_near (req_data.color_end_a),
      .color_far  (req_data.color_end_b),
      .color_mix  (mix_near)
   );

   bcd_color_lane u_color_far (
      .color_near (req_data.color_end_b),
      .color_far  (req_data.color_end_a),
      .color_mix  (mix_far)
   );

   for (genvar j = 0; j < bcd_pkg::ALPHA_LANES; j++) begin : g_alpha
      bcd_alpha_lane u_lane (
         .clock     (clock),
         .load      (accept),
         .step      (3'(j + 2)),
         .alpha_a   (req_data.alpha_word[7:0]),
         .alpha_b   (req_data.alpha_word[15:8]),
         .mix_seven (lane_seven[j]),
         .mix_five  (lane_five[j])
      );
   end

   always_comb begin
      block_format_in = csr_valid ? csr_data : block_format_ff;
      blk_valid_in    = accept ? 1'b1 : (load ? 1'b0 : blk_valid_ff);
      blk_in          = blk_ff;
      if (accept) begin
         blk_in.fmt              = block_format_ff;
         blk_in.alpha_word       = req_data.alpha_word;
         blk_in.color_index_word = req_data.color_index_word;
         blk_in.palette          = {mix_far, mix_near,
                                    req_data.color_end_b, req_data.color_end_a};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         blk_valid_ff    <= 1'b0;
         block_format_ff <= bcd_pkg::FMT_BC1;
      end else begin
         blk_valid_ff    <= blk_valid_in;
         block_format_ff <= block_format_in;
      end
      blk_ff <= blk_in;
   end

   bcd_pixel_merge u_merge (
      .clock       (clock),
      .reset       (reset),
      .load        (load),
      .blk         (blk_ff),
      .lane_seven  (lane_seven),
      .lane_five   (lane_five),
      .free        (merge_free),
      .pixel_valid (rsp_strobe),
      .pixel       (rsp_data)
   );

endmodule
`default_nettype wire

@@ rtl/bcd_color_lane.sv @@
// Colour lane: one interpolated RGB565 palette entry, (2*a + b) / 3 per field, (2*a + b + 1) / 3 in blue.
`timescale 1ns / 1ps
`default_nettype none
module bcd_color_lane (
   input  wire logic [15:0] color_near,
   input  wire logic [15:0] color_far,
   output logic [15:0]      color_mix
);

   logic [7:0] red_sum;
   logic [7:0] green_sum;
   logic [7:0] blue_sum;
   logic [6:0] red_q;
   logic [6:0] green_q;
   logic [6:0] blue_q;

   // rounding term only survives the mask in the blue field
   always_comb begin
      red_sum   = {2'd0, color_near[15:11], 1'b0} + {3'd0, color_far[15:11]};
      green_sum = {1'b0, color_near[10:5], 1'b0} + {2'd0, color_far[10:5]};
      blue_sum  = {2'd0, color_near[4:0], 1'b0} + {3'd0, color_far[4:0]} + 8'd1;
      red_q     = bcd_pkg::div3(red_sum);
      green_q   = bcd_pkg::div3(green_sum);
      blue_q    = bcd_pkg::div3(blue_sum);
      color_mix = {red_q[4:0], green_q[5:0], blue_q[4:0]};
   end

endmodule
`default_nettype wire

@@ rtl/bcd_alpha_lane.sv @@
// Alpha lane: weighted sums for one BC3 palette entry in both interpolation modes, registered, then scaled.
`timescale 1ns / 1ps
`default_nettype none
module bcd_alpha_lane (
   input  wire logic       clock,
   input  wire logic       load,
   input  wire logic [2:0] step,
   input  wire logic [7:0] alpha_a,
   input  wire logic [7:0] alpha_b,
   output logic [7:0]      mix_seven,
   output logic [7:0]      mix_five
);

   logic [3:0]  wa7;
   logic [2:0]  wa5;
   logic [2:0]  wb;
   logic [12:0] s7_full;
   logic [11:0] s5_full;
   logic [10:0] sum7_ff;
   logic [10:0] sum7_in;
   logic [10:0] sum5_ff;
   logic [10:0] sum5_in;

   always_comb begin
      wa7     = 4'd8 - {1'b0, step};
      wa5     = 3'd6 - step;
      wb      = step - 3'd1;
      s7_full = {5'd0, alpha_a} * {9'd0, wa7} + {5'd0, alpha_b} * {10'd0, wb};
      s5_full = {4'd0, alpha_a} * {9'd0, wa5} + {4'd0, alpha_b} * {9'd0, wb};
      sum7_in = load ? s7_full[10:0] : sum7_ff;
      sum5_in = load ? s5_full[10:0] : sum5_ff;
   end

   always_ff @(posedge clock) begin
      sum7_ff <= sum7_in;
      sum5_ff <= sum5_in;
   end

   assign mix_seven = bcd_pkg::div7(sum7_ff);
   assign mix_five  = bcd_pkg::div5(sum5_ff);

endmodule
`default_nettype wire

@@ rtl/bcd_pixel_merge.sv @@
// Merge stage: builds the alpha palette from the lanes and emits one pixel per cycle.
`timescale 1ns / 1ps
`default_nettype none
module bcd_pixel_merge (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    load,
   input  wire bcd_pkg::bcd_block_type  blk,
   input  wire logic [5:0][7:0]         lane_seven,
   input  wire logic [5:0][7:0]         lane_five,
   output logic                         free,
   output logic                         pixel_valid,
   output bcd_pkg::bcd_rsp_type         pixel
);

   logic                   valid_ff;
   logic                   valid_in;
   logic [3:0]             cnt_ff;
   logic [3:0]             cnt_in;
   logic [1:0]             fmt_ff;
   logic [1:0]             fmt_in;
   logic [3:0][15:0]       cpal_ff;
   logic [3:0][15:0]       cpal_in;
   logic [7:0][7:0]        apal_ff;
   logic [7:0][7:0]        apal_in;
   logic [31:0]            ci_ff;
   logic [31:0]            ci_in;
   logic [63:0]            aw_ff;
   logic [63:0]            aw_in;
   logic                   last;
   logic                   wide_step;
   logic [7:0]             alpha;
   logic [7:0]             a0;
   logic [7:0]             a1;

   assign last = (cnt_ff == bcd_pkg::LAST_PIXEL);
   assign free = !valid_ff || last;

   always_comb begin
      a0 = blk.alpha_word[7:0];
      a1 = blk.alpha_word[15:8];
      apal_in[0] = a0;
      apal_in[1] = a1;
      for (int j = 0; j < bcd_pkg::ALPHA_LANES; j++) begin
         if (a0 > a1) begin
            apal_in[j + 2] = lane_seven[j];
         end else if (j < 4) begin
            apal_in[j + 2] = lane_five[j];
         end else if (j == 4) begin
            apal_in[j + 2] = 8'd0;
         end else begin
            apal_in[j + 2] = bcd_pkg::ALPHA_OPAQUE;
         end
      end
   end

   always_comb begin
      wide_step = (fmt_ff == bcd_pkg::FMT_BC2);
      unique case (fmt_ff)
         bcd_pkg::FMT_BC1: alpha = 8'd0;
         bcd_pkg::FMT_BC2: alpha = {4'd0, aw_ff[3:0]};
         default:          alpha = apal_ff[aw_ff[2:0]];
      endcase
      pixel.pixel_color    = cpal_ff[ci_ff[1:0]];
      pixel.pixel_alpha    = alpha;
      pixel.pixel_position = cnt_ff;
      pixel.block_last     = last;
      pixel_valid          = valid_ff;
   end

   always_comb begin
      valid_in = valid_ff;
      cnt_in   = cnt_ff;
      fmt_in   = fmt_ff;
      cpal_in  = cpal_ff;
      ci_in    = ci_ff;
      aw_in    = aw_ff;
      if (load) begin
         valid_in = 1'b1;
         cnt_in   = 4'd0;
         fmt_in   = blk.fmt;
         cpal_in  = blk.palette;
         ci_in    = blk.color_index_word;
         if (blk.fmt[1]) begin
            aw_in = blk.alpha_word >> bcd_pkg::BC3_IDX_LSB;
         end else begin
            aw_in = blk.alpha_word;
         end
      end else if (valid_ff) begin
         valid_in = !last;
         cnt_in   = cnt_ff + 4'd1;
         ci_in    = ci_ff >> 2;
         aw_in    = wide_step ? (aw_ff >> 4) : (aw_ff >> 3);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         cnt_ff   <= 4'd0;
      end else begin
         valid_ff <= valid_in;
         cnt_ff   <= cnt_in;
      end
      fmt_ff  <= fmt_in;
      cpal_ff <= cpal_in;
      ci_ff   <= ci_in;
      aw_ff   <= aw_in;
      if (load) begin
         apal_ff <= apal_in;
      end
   end

endmodule
`default_nettype wire

@@ tb/tb.sv @@
// Self-checking bench for the BC1/BC2/BC3 block decoder: queued driver, predictor, pixel monitor.
`timescale 1ns / 1ps
module tb;

   localparam logic [1:0] FMT_ALT_BC3 = 2'd3;   // unused code, decodes as BC3
   localparam int unsigned DRAIN_CYCLES = 4;
   localparam int unsigned TAIL_CYCLES = 8;
   localparam int unsigned BLOCKS_PER_PHASE = 50;
   localparam int unsigned RANDOM_PHASES = 9;

   typedef struct {
      logic                 is_cfg;
      logic [1:0]           fmt;
      bcd_pkg::bcd_req_type blk;
   } block_job_type;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 start = 1'b0;
   logic                 busy;
   bcd_pkg::bcd_req_type req_data = '0;
   logic                 rsp_strobe;
   bcd_pkg::bcd_rsp_type rsp_data;
   logic                 csr_valid = 1'b0;
   logic                 csr_ready;
   logic [1:0]           csr_data = bcd_pkg::FMT_BC1;

   block_job_type        job_queue[$];
   bcd_pkg::bcd_rsp_type pending_pixels[$];
   logic [1:0]  fmt_shadow = bcd_pkg::FMT_BC1;
   logic        req_taken = 1'b0;
   logic        cfg_taken = 1'b0;
   int unsigned gap_left = 0;
   int unsigned calm_left = 0;
   int unsigned drain_wait = 0;
   int unsigned error_count = 0;
   int unsigned blocks_taken = 0;
   int unsigned pixels_checked = 0;
   int unsigned fmt_writes = 0;

   bc1_bc2_bc3_block_decoder i_dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_data   (req_data),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   function automatic int unsigned mix_third(input int unsigned c0, input int unsigned c1,
                                             input int unsigned mask);
      return ((2 * (c0 & mask) + (c1 & mask) + 1) / 3) & mask;
   endfunction

   function automatic int unsigned blend_color(input int unsigned c0, input int unsigned c1);
      return mix_third(c0, c1, 'hF800) | mix_third(c0, c1, 'h07E0) |
             mix_third(c0, c1, 'h001F);
   endfunction

   task automatic predict_pixels(input logic [1:0] fmt, input bcd_pkg::bcd_req_type blk);
      int unsigned cpal[4];
      int unsigned apal[8];
      int unsigned a0;
      int unsigned a1;
      bcd_pkg::bcd_rsp_type px;
      cpal[0] = blk.color_end_a;
      cpal[1] = blk.color_end_b;
      cpal[2] = blend_color(blk.color_end_a, blk.color_end_b);
      cpal[3] = blend_color(blk.color_end_b, blk.color_end_a);
      a0 = blk.alpha_word[7:0];
      a1 = blk.alpha_word[15:8];
      apal[0] = a0;
      apal[1] = a1;
      if (a0 > a1) begin
         for (int k = 2; k < 8; k++) apal[k] = ((8 - k) * a0 + (k - 1) * a1) / 7;
      end else begin
         for (int k = 2; k < 6; k++) apal[k] = ((6 - k) * a0 + (k - 1) * a1) / 5;
         apal[6] = 0;
         apal[7] = bcd_pkg::ALPHA_OPAQUE;
      end
      for (int p = 0; p < bcd_pkg::PIXELS; p++) begin
         px.pixel_color = 16'(cpal[blk.color_index_word[2*p +: 2]]);
         case (fmt)
            bcd_pkg::FMT_BC1: px.pixel_alpha = 8'd0;
            bcd_pkg::FMT_BC2: px.pixel_alpha = {4'd0, blk.alpha_word[4*p +: 4]};
            default: px.pixel_alpha =
                        8'(apal[blk.alpha_word[bcd_pkg::BC3_IDX_LSB + 3*p +: 3]]);
         endcase
         px.pixel_position = 4'(p);
         px.block_last = (4'(p) == bcd_pkg::LAST_PIXEL);
         pending_pixels.push_back(px);
      end
   endtask

   function automatic int unsigned pick_gap();
      int unsigned r;
      if (calm_left > 0) begin
         calm_left--;
         return 0;
      end
      r = $urandom_range(0, 99);
      if (r < 5) begin
         calm_left = $urandom_range(10, 40);
         return 0;
      end
      if (r < 45) return 0;
      if (r < 80) return $urandom_range(1, 3);
      if (r < 96) return $urandom_range(4, 17);
      return $urandom_range(18, 60);
   endfunction

   // alpha endpoints plus BC3 indices walking 0..7
   function automatic logic [63:0] walk_alpha(input logic [7:0] a0, input logic [7:0] a1);
      logic [63:0] w;
      w = {48'd0, a1, a0};
      for (int p = 0; p < bcd_pkg::PIXELS; p++) w[bcd_pkg::BC3_IDX_LSB + 3*p +: 3] = 3'(p);
      return w;
   endfunction

   function automatic bcd_pkg::bcd_req_type rand_block();
      bcd_pkg::bcd_req_type b;
      b.alpha_word = {$urandom, $urandom};
      b.color_end_a = 16'($urandom);
      b.color_end_b = 16'($urandom);
      b.color_index_word = $urandom;
      case ($urandom_range(0, 11))
         0: b.color_end_b = b.color_end_a;
         1: b.alpha_word[15:8] = b.alpha_word[7:0];
         2: b.alpha_word[15:0] = {8'h00, 8'hFF};
         3: b.alpha_word[15:0] = {8'hFF, 8'h00};
         4: b.color_end_a = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
         default: ;
      endcase
      return b;
   endfunction

   task automatic add_block(input bcd_pkg::bcd_req_type b);
      block_job_type j;
      j.is_cfg = 1'b0;
      j.fmt = bcd_pkg::FMT_BC1;
      j.blk = b;
      job_queue.push_back(j);
   endtask

   task automatic add_format(input logic [1:0] fmt);
      block_job_type j;
      j.is_cfg = 1'b1;
      j.fmt = fmt;
      j.blk = '0;
      job_queue.push_back(j);
   endtask

   // driver: one request or one format write in flight
   always @(negedge clock) begin
      logic nxt_start;
      logic nxt_csr;
      block_job_type j;
      nxt_start = start;
      nxt_csr = csr_valid;
      if (!reset) begin
         if (start && req_taken) nxt_start = 1'b0;
         if (csr_valid && cfg_taken) nxt_csr = 1'b0;
         if (!nxt_start && !nxt_csr) begin
            if (gap_left > 0) begin
               gap_left--;
            end else if (job_queue.size() > 0) begin
               if (job_queue[0].is_cfg) begin
                  if (pending_pixels.size() != 0) begin
                     drain_wait = 0;
                  end else if (drain_wait < DRAIN_CYCLES) begin
                     drain_wait++;
                  end else begin
                     j = job_queue.pop_front();
                     csr_data <= j.fmt;
                     nxt_csr = 1'b1;
                     drain_wait = 0;
                     gap_left = pick_gap();
                  end
               end else begin
                  j = job_queue.pop_front();
                  req_data <= j.blk;
                  nxt_start = 1'b1;
                  gap_left = pick_gap();
               end
            end
         end
      end
      start <= nxt_start;
      csr_valid <= nxt_csr;
   end

   // monitor: check pixels, then record accepted requests and format writes
   always @(posedge clock) begin
      bcd_pkg::bcd_rsp_type want;
      if (!reset) begin
         if (rsp_strobe === 1'b1) begin
            if (pending_pixels.size() == 0) begin
               $error("pixel with no pending block: %p", rsp_data);
               error_count++;
            end else begin
               want = pending_pixels.pop_front();
               pixels_checked++;
               if (rsp_data.pixel_color !== want.pixel_color) begin
                  $error("pixel_color: expected %h, actual %h",
                         want.pixel_color, rsp_data.pixel_color);
                  error_count++;
               end
               if (rsp_data.pixel_alpha !== want.pixel_alpha) begin
                  $error("pixel_alpha: expected %h, actual %h",
                         want.pixel_alpha, rsp_data.pixel_alpha);
                  error_count++;
               end
               if (rsp_data.pixel_position !== want.pixel_position) begin
                  $error("pixel_position: expected %0d, actual %0d",
                         want.pixel_position, rsp_data.pixel_position);
                  error_count++;
               end
               if (rsp_data.block_last !== want.block_last) begin
                  $error("block_last: expected %b, actual %b",
                         want.block_last, rsp_data.block_last);
                  error_count++;
               end
            end
         end else if (rsp_strobe !== 1'b0) begin
            $error("rsp_strobe unknown");
            error_count++;
         end
         if (start && busy === 1'b0) begin
            predict_pixels(fmt_shadow, req_data);
            blocks_taken++;
         end
         if (csr_valid && csr_ready === 1'b1) begin
            fmt_shadow = csr_data;
            fmt_writes++;
         end
      end
      req_taken <= start && busy === 1'b0;
      cfg_taken <= csr_valid && csr_ready === 1'b1;
   end

   initial begin
      logic [1:0] fmts[4];
      bcd_pkg::bcd_req_type b;
      fmts = '{bcd_pkg::FMT_BC1, bcd_pkg::FMT_BC2, bcd_pkg::FMT_BC3, FMT_ALT_BC3};
      foreach (fmts[f]) begin
         add_format(fmts[f]);
         add_block('0);
         add_block('1);
         b.color_end_a = 16'hFFFF;
         b.color_end_b = 16'h0000;
         b.color_index_word = 32'hE4E4E4E4;
         b.alpha_word = walk_alpha(8'hFF, 8'h00);
         add_block(b);
         b.color_end_a = 16'h0000;
         b.color_end_b = 16'hFFFF;
         b.alpha_word = walk_alpha(8'h00, 8'hFF);
         add_block(b);
         b = rand_block();
         b.color_end_b = b.color_end_a;
         b.alpha_word = walk_alpha(b.alpha_word[7:0], b.alpha_word[7:0]);
         add_block(b);
         b = rand_block();
         b.alpha_word = 64'hFEDCBA9876543210;
         add_block(b);
      end
      for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
         add_format(ph < 4 ? fmts[ph] : 2'($urandom_range(0, 3)));
         for (int i = 0; i < BLOCKS_PER_PHASE; i++) add_block(rand_block());
      end

      repeat (12) @(posedge clock);
      @(negedge clock) reset <= 1'b0;

      while (job_queue.size() != 0 || start || csr_valid || pending_pixels.size() != 0)
         @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("covered %0d blocks over %0d format writes (BC1, BC2, BC3 and the spare code)",
               blocks_taken, fmt_writes);
      $display("%0d pixels compared, %0d errors", pixels_checked, error_count);
      if (error_count == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

   initial begin
      #2_000_000;
      $display("timeout: %0d pixels still pending", pending_pixels.size());
      $display("end of test: mismatches");
      $finish;
   end

endmodule

@@ bc1_bc2_bc3_block_decoder.f @@
rtl/bcd_pkg.sv
rtl/bcd_color_lane.sv
rtl/bcd_alpha_lane.sv
rtl/bcd_pixel_merge.sv
rtl/bc1_bc2_bc3_block_decoder.sv
tb/tb.sv
